[src/vmcs_field_encoding_checker_defines.svh]
// assertion macros for the encoding checker
`ifndef VMCS_FIELD_ENCODING_CHECKER_DEFINES_SVH
`define VMCS_FIELD_ENCODING_CHECKER_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define VFEC_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("vfec: check failed");

// next-cycle implication
`define VFEC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("vfec: check failed");

`else

`define VFEC_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define VFEC_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

[src/vfec_pkg.sv]
`default_nettype none

package vfec_pkg;

  localparam int ENC_W     = 32;
  localparam int BASE_W    = 15;
  localparam int WIDTH_W   = 4;
  localparam int STATUS_W  = 2;
  localparam int CAP_W     = 32;
  localparam int CFG_IDX_W = 3;
  localparam int NUM_RANGES = 19;

  // status codes
  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_MALFORMED = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_NOT_IMPL  = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PIN       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PRIMARY   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SECONDARY = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_EXIT      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ENTRY     = 3'd4;

  // width class with 64-bit fields
  localparam logic [1:0] CLASS_64 = 2'd1;
  // field type of exit information
  localparam logic [1:0] TYPE_EXIT_INFO = 2'd1;

  localparam logic [BASE_W-1:0] RANGE_LO [NUM_RANGES] = '{
    15'h0000, 15'h0800, 15'h0c00, 15'h2000, 15'h2010, 15'h201a, 15'h2032, 15'h2400,
    15'h2800, 15'h2c00, 15'h4000, 15'h4400, 15'h4800, 15'h482e, 15'h4c00, 15'h6000,
    15'h6400, 15'h6800, 15'h6c00
  };

  localparam logic [BASE_W-1:0] RANGE_HI [NUM_RANGES] = '{
    15'h0002, 15'h0810, 15'h0c0c, 15'h200c, 15'h2016, 15'h2022, 15'h2032, 15'h2400,
    15'h2810, 15'h2c04, 15'h4022, 15'h440e, 15'h482a, 15'h482e, 15'h4c00, 15'h600e,
    15'h640a, 15'h6826, 15'h6c16
  };

  localparam logic [WIDTH_W-1:0] WIDTH_OF_CLASS [4] = '{4'd2, 4'd8, 4'd4, 4'd8};

  typedef struct packed {
    logic [CAP_W-1:0] pin;
    logic [CAP_W-1:0] primary;
    logic [CAP_W-1:0] secondary;
    logic [CAP_W-1:0] exit_ctl;
    logic [CAP_W-1:0] entry_ctl;
  } caps_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [BASE_W-1:0]   base_encoding;
    logic [WIDTH_W-1:0]  width_bytes;
    logic                read_only;
    logic                upper_half;
    logic                available;
  } result_t;

endpackage

`default_nettype wire

[src/vfec_if.sv]
`default_nettype none

interface vfec_req_if;
  logic                      valid;
  logic                      ready;
  logic [vfec_pkg::ENC_W-1:0] field_encoding;

  modport source (output valid, output field_encoding, input ready);
  modport sink (input valid, input field_encoding, output ready);
endinterface

interface vfec_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [vfec_pkg::STATUS_W-1:0] status;
  logic [vfec_pkg::BASE_W-1:0]   base_encoding;
  logic [vfec_pkg::WIDTH_W-1:0]  width_bytes;
  logic                         read_only;
  logic                         upper_half;
  logic                         available;

  modport source (
    output valid, output status, output base_encoding, output width_bytes,
    output read_only, output upper_half, output available, input ready
  );
  modport sink (
    input valid, input status, input base_encoding, input width_bytes,
    input read_only, input upper_half, input available, output ready
  );
endinterface

`default_nettype wire

[src/vfec_cfg_regs.sv]
`default_nettype none

module vfec_cfg_regs (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_write,
  input  wire logic [vfec_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [vfec_pkg::CAP_W-1:0]     cfg_data,
  output vfec_pkg::caps_t                     caps
);
  import vfec_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      caps <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_PIN:       caps.pin       <= cfg_data;
        REG_PRIMARY:   caps.primary   <= cfg_data;
        REG_SECONDARY: caps.secondary <= cfg_data;
        REG_EXIT:      caps.exit_ctl  <= cfg_data;
        REG_ENTRY:     caps.entry_ctl <= cfg_data;
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[src/vfec_decode.sv]
`default_nettype none

module vfec_decode (
  input  wire logic [vfec_pkg::ENC_W-1:0] encoding,
  input  wire vfec_pkg::caps_t            caps,
  output vfec_pkg::result_t               result
);
  import vfec_pkg::*;

  logic [BASE_W-1:0] base;
  logic [1:0]        cls;
  logic              high;
  logic              malformed;
  logic              in_range;
  logic              enabled;

  assign malformed = |encoding[ENC_W-1:BASE_W];
  assign cls       = encoding[14:13];
  assign high      = encoding[0];
  assign base      = {encoding[BASE_W-1:1], 1'b0};

  // parallel range compares
  always_comb begin
    in_range = 1'b0;
    for (int i = 0; i < NUM_RANGES; i++) begin
      if (base >= RANGE_LO[i] && base <= RANGE_HI[i]) begin
        in_range = 1'b1;
      end
    end
  end

  // capability gating per field
  always_comb begin
    unique case (base)
      15'h0000: enabled = caps.secondary[5];
      15'h0002,
      15'h2016: enabled = caps.pin[7];
      15'h0810,
      15'h201c,
      15'h201e,
      15'h2020,
      15'h2022: enabled = caps.secondary[9];
      15'h2012,
      15'h401c: enabled = caps.primary[21];
      15'h2014: enabled = caps.secondary[0];
      15'h201a,
      15'h2400: enabled = caps.secondary[1];
      15'h2032: enabled = caps.secondary[25];
      15'h2802: enabled = caps.entry_ctl[2] | caps.exit_ctl[2];
      15'h2804: enabled = caps.entry_ctl[14] | caps.exit_ctl[18];
      15'h2806: enabled = caps.entry_ctl[15] | caps.exit_ctl[20];
      15'h2808: enabled = caps.entry_ctl[13] | caps.exit_ctl[30];
      15'h2c00: enabled = caps.exit_ctl[19];
      15'h2c02: enabled = caps.exit_ctl[21];
      15'h2c04: enabled = caps.exit_ctl[12];
      15'h401e: enabled = caps.primary[31];
      15'h482e: enabled = caps.pin[6];
      default:  enabled = 1'b1;
    endcase
  end

  always_comb begin
    result = '0;
    if (malformed) begin
      result.status = STATUS_MALFORMED;
    end else if ((high && cls != CLASS_64) || !in_range) begin
      result.status = STATUS_NOT_IMPL;
    end else begin
      result.status        = STATUS_OK;
      result.base_encoding = base;
      result.width_bytes   = WIDTH_OF_CLASS[cls];
      result.read_only     = (base[11:10] == TYPE_EXIT_INFO);
      result.upper_half    = high;
      result.available     = enabled;
    end
  end

endmodule

`default_nettype wire

[src/vmcs_field_encoding_checker.sv]
// Checks and decodes one 32-bit field encoding per word. A word accepted on req
// is registered, decoded combinationally against the fixed implemented ranges
// and the five allowed-one capability registers, and held in a result register
// until rsp takes it. With rsp ready the block takes one word every cycle, as
// the decode between the input and result registers is combinational. While a
// result waits, the input register takes one more word and req then stalls
// until rsp takes the result. Capability registers are written through
// cfg_write, cfg_index and cfg_data (indexes 0 to 4: pin, primary, secondary,
// exit, entry; others are ignored), reset to zero, and must only change while
// the block is idle.
`default_nettype none

`include "vmcs_field_encoding_checker_defines.svh"

module vmcs_field_encoding_checker (
  input  wire logic                           clk,
  input  wire logic                           rst,
  vfec_req_if.sink                            req,
  vfec_rsp_if.source                          rsp,
  input  wire logic                           cfg_write,
  input  wire logic [vfec_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [vfec_pkg::CAP_W-1:0]     cfg_data
);
  import vfec_pkg::*;

  caps_t             caps;
  result_t           dec_res;
  result_t           out_res;
  logic              stage_valid;
  logic [ENC_W-1:0]  stage_enc;
  logic              out_valid;
  logic              advance;

  vfec_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .caps      (caps)
  );

  vfec_decode u_decode (
    .encoding (stage_enc),
    .caps     (caps),
    .result   (dec_res)
  );

  assign advance   = !out_valid || rsp.ready;
  assign req.ready = !stage_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (req.ready) begin
        stage_valid <= req.valid;
      end
      if (advance) begin
        out_valid <= stage_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      stage_enc <= req.field_encoding;
    end
    if (advance && stage_valid) begin
      out_res <= dec_res;
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.status        = out_res.status;
  assign rsp.base_encoding = out_res.base_encoding;
  assign rsp.width_bytes   = out_res.width_bytes;
  assign rsp.read_only     = out_res.read_only;
  assign rsp.upper_half    = out_res.upper_half;
  assign rsp.available     = out_res.available;

  `VFEC_ASSERT_NEXT(a_accept_fills_stage, clk, rst, req.valid && req.ready, stage_valid)
  `VFEC_ASSERT_IMPLY(a_error_clears_fields, clk, rst, rsp.valid && rsp.status != STATUS_OK, rsp.base_encoding == '0 && rsp.width_bytes == '0 && !rsp.available && !rsp.upper_half)
  `VFEC_ASSERT_IMPLY(a_available_ok, clk, rst, rsp.valid && rsp.available, rsp.status == STATUS_OK)
  `VFEC_ASSERT_IMPLY(a_ok_has_width, clk, rst, rsp.valid && rsp.status == STATUS_OK, rsp.width_bytes != '0 && !rsp.base_encoding[0])
  `VFEC_ASSERT_IMPLY(a_high_is_64bit, clk, rst, rsp.valid && rsp.upper_half, rsp.width_bytes == 4'd8)

endmodule

`default_nettype wire

[verif/tb.sv]
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import vfec_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int unsigned HOLD_CYCLES = 250;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int NUM_IMPL = 19;
  localparam int NUM_GATED = 23;
  localparam int NUM_CORNERS = 25;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_UNUSED = REG_ENTRY + 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LAST_UNUSED = '1;

  // implemented field ranges, inclusive
  localparam logic [BASE_W-1:0] IMPL_FIRST [NUM_IMPL] = '{
    15'h0000, 15'h0800, 15'h0c00, 15'h2000, 15'h2010, 15'h201a, 15'h2032, 15'h2400,
    15'h2800, 15'h2c00, 15'h4000, 15'h4400, 15'h4800, 15'h482e, 15'h4c00, 15'h6000,
    15'h6400, 15'h6800, 15'h6c00
  };
  localparam logic [BASE_W-1:0] IMPL_LAST [NUM_IMPL] = '{
    15'h0002, 15'h0810, 15'h0c0c, 15'h200c, 15'h2016, 15'h2022, 15'h2032, 15'h2400,
    15'h2810, 15'h2c04, 15'h4022, 15'h440e, 15'h482a, 15'h482e, 15'h4c00, 15'h600e,
    15'h640a, 15'h6826, 15'h6c16
  };
  localparam logic [WIDTH_W-1:0] BYTES_PER_CLASS [4] = '{4'd2, 4'd8, 4'd4, 4'd8};

  // fields that depend on a capability bit
  localparam logic [BASE_W-1:0] GATED_FIELDS [NUM_GATED] = '{
    15'h0000, 15'h0002, 15'h2016, 15'h0810, 15'h201c, 15'h201e, 15'h2020, 15'h2022,
    15'h2012, 15'h401c, 15'h2014, 15'h201a, 15'h2400, 15'h2032, 15'h2802, 15'h2804,
    15'h2806, 15'h2808, 15'h2c00, 15'h2c02, 15'h2c04, 15'h401e, 15'h482e
  };

  localparam logic [ENC_W-1:0] CORNER_ENCODINGS [NUM_CORNERS] = '{
    32'h0000_0000, 32'hffff_ffff, 32'h0000_8000, 32'h8000_0000, 32'h0000_7fff,
    32'h0000_2001, 32'h0000_2013, 32'h0000_0001, 32'h0000_0c0d, 32'h0000_4400,
    32'h0000_440f, 32'h0000_6c16, 32'h0000_6c18, 32'h0000_482e, 32'h0000_482c,
    32'h0000_4c00, 32'h0000_4c02, 32'h0000_2033, 32'h0000_2034, 32'h0000_2400,
    32'h0000_6826, 32'h0000_2810, 32'h0000_2811, 32'h0000_0004, 32'h0000_7ffe
  };

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CAP_W-1:0] cfg_data;

  vfec_req_if req ();
  vfec_rsp_if rsp ();

  vmcs_field_encoding_checker dut (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  caps_t cap_model;
  result_t pending_decodes [$];
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  logic tx_gaps = 1'b0;
  logic rx_gaps = 1'b0;
  logic hold_off = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("[vmcs_field_encoding_checker] ERROR");
    $finish;
  end

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic field_gated_on(input logic [BASE_W-1:0] base);
    case (base)
      15'h0000: return cap_model.secondary[5];
      15'h0002, 15'h2016: return cap_model.pin[7];
      15'h0810, 15'h201c, 15'h201e, 15'h2020, 15'h2022: return cap_model.secondary[9];
      15'h2012, 15'h401c: return cap_model.primary[21];
      15'h2014: return cap_model.secondary[0];
      15'h201a, 15'h2400: return cap_model.secondary[1];
      15'h2032: return cap_model.secondary[25];
      15'h2802: return cap_model.entry_ctl[2] | cap_model.exit_ctl[2];
      15'h2804: return cap_model.entry_ctl[14] | cap_model.exit_ctl[18];
      15'h2806: return cap_model.entry_ctl[15] | cap_model.exit_ctl[20];
      15'h2808: return cap_model.entry_ctl[13] | cap_model.exit_ctl[30];
      15'h2c00: return cap_model.exit_ctl[19];
      15'h2c02: return cap_model.exit_ctl[21];
      15'h2c04: return cap_model.exit_ctl[12];
      15'h401e: return cap_model.primary[31];
      15'h482e: return cap_model.pin[6];
      default: return 1'b1;
    endcase
  endfunction

  function automatic result_t decode_encoding(input logic [ENC_W-1:0] enc);
    result_t r;
    logic [1:0] cls;
    logic [BASE_W-1:0] base;
    logic hit;
    r = '0;
    if (enc[ENC_W-1:BASE_W] != '0) begin
      r.status = STATUS_MALFORMED;
      return r;
    end
    cls = enc[14:13];
    base = {enc[BASE_W-1:1], 1'b0};
    hit = 1'b0;
    for (int i = 0; i < NUM_IMPL; i++)
      if (base >= IMPL_FIRST[i] && base <= IMPL_LAST[i]) hit = 1'b1;
    if ((enc[0] && cls != CLASS_64) || !hit) begin
      r.status = STATUS_NOT_IMPL;
      return r;
    end
    r.status = STATUS_OK;
    r.base_encoding = base;
    r.width_bytes = BYTES_PER_CLASS[cls];
    r.read_only = (base[11:10] == TYPE_EXIT_INFO);
    r.upper_half = enc[0];
    r.available = field_gated_on(base);
    return r;
  endfunction

  function automatic logic [CAP_W-1:0] random_cap_word();
    logic [CAP_W-1:0] w;
    w = '0;
    case ($urandom_range(0, 3))
      0: w = '0;
      1: w = '1;
      2: w[$urandom_range(0, CAP_W - 1)] = 1'b1;
      default: w = $urandom;
    endcase
    return w;
  endfunction

  function automatic caps_t random_caps();
    caps_t c;
    c.pin = random_cap_word();
    c.primary = random_cap_word();
    c.secondary = random_cap_word();
    c.exit_ctl = random_cap_word();
    c.entry_ctl = random_cap_word();
    return c;
  endfunction

  function automatic logic [ENC_W-1:0] random_encoding();
    logic [ENC_W-1:0] enc;
    int unsigned pick;
    int unsigned k;
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      k = $urandom_range(0, NUM_IMPL - 1);
      enc = ENC_W'(IMPL_FIRST[k]) +
            2 * $urandom_range(0, (IMPL_LAST[k] - IMPL_FIRST[k]) / 2);
      if (enc[14:13] == CLASS_64 && $urandom_range(0, 1) == 1) enc[0] = 1'b1;
    end else if (pick < 85) begin
      enc = $urandom_range(0, (1 << BASE_W) - 1);
    end else if (pick < 93) begin
      enc = $urandom | (32'h0000_8000 << $urandom_range(0, ENC_W - BASE_W - 1));
    end else begin
      enc = (32'h1 << $urandom_range(BASE_W, ENC_W - 1)) | $urandom_range(0, (1 << BASE_W) - 1);
    end
    return enc;
  endfunction

  task automatic send_word(input logic [ENC_W-1:0] enc);
    req.valid <= 1'b1;
    req.field_encoding <= enc;
    do @(posedge clk); while (!req.ready);
    pending_decodes.push_back(decode_encoding(enc));
    if (tx_gaps && $urandom_range(0, 3) == 0) begin
      req.valid <= 1'b0;
      repeat (gap_len()) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    req.valid <= 1'b0;
    while (pending_decodes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CAP_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
  endtask

  task automatic load_caps(input caps_t c);
    write_reg(REG_PIN, c.pin);
    write_reg(REG_PRIMARY, c.primary);
    write_reg(REG_SECONDARY, c.secondary);
    write_reg(REG_EXIT, c.exit_ctl);
    write_reg(REG_ENTRY, c.entry_ctl);
    // writes to unused indexes must not land anywhere
    write_reg(CFG_IDX_W'($urandom_range(REG_FIRST_UNUSED, REG_LAST_UNUSED)), $urandom);
    cfg_write <= 1'b0;
    cap_model = c;
  endtask

  task automatic report_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
    $display("%0t: %s expected %0h actual %0h", $time, what, want, got);
    mismatches++;
  endtask

  // result checker
  always @(posedge clk) begin
    result_t want;
    result_t got;
    if (!rst && rsp.valid && rsp.ready) begin
      got.status = rsp.status;
      got.base_encoding = rsp.base_encoding;
      got.width_bytes = rsp.width_bytes;
      got.read_only = rsp.read_only;
      got.upper_half = rsp.upper_half;
      got.available = rsp.available;
      if (pending_decodes.size() == 0) begin
        $display("%0t: word with nothing expected, actual %0h", $time, got);
        mismatches++;
      end else begin
        want = pending_decodes.pop_front();
        if (got.status !== want.status)
          report_mismatch("status", want.status, got.status);
        if (got.base_encoding !== want.base_encoding)
          report_mismatch("base_encoding", want.base_encoding, got.base_encoding);
        if (got.width_bytes !== want.width_bytes)
          report_mismatch("width_bytes", want.width_bytes, got.width_bytes);
        if (got.read_only !== want.read_only)
          report_mismatch("read_only", want.read_only, got.read_only);
        if (got.upper_half !== want.upper_half)
          report_mismatch("upper_half", want.upper_half, got.upper_half);
        if (got.available !== want.available)
          report_mismatch("available", want.available, got.available);
      end
    end
  end

  // output side, stalls counted here
  initial begin : rsp_side
    int unsigned stall;
    rsp.ready <= 1'b0;
    @(posedge clk);
    forever begin
      stall = 0;
      if (hold_off) begin
        stall = HOLD_CYCLES;
        hold_off = 1'b0;
      end else if (rx_gaps && $urandom_range(0, 3) == 0) begin
        stall = gap_len();
      end
      rsp.ready <= (stall == 0);
      repeat (stall == 0 ? 1 : stall) @(posedge clk);
    end
  end

  task automatic test_decode_corners();
    foreach (CORNER_ENCODINGS[i]) send_word(CORNER_ENCODINGS[i]);
    wait_idle();
  endtask

  task automatic test_capability_gating();
    caps_t c;
    for (int pass = 0; pass < 5; pass++) begin
      if (pass == 0) c = '0;
      else if (pass == 1) c = '1;
      else c = random_caps();
      tx_gaps = (pass >= 3);
      rx_gaps = (pass >= 2);
      load_caps(c);
      foreach (GATED_FIELDS[i]) begin
        send_word(ENC_W'(GATED_FIELDS[i]));
        if (GATED_FIELDS[i][14:13] == CLASS_64) send_word(ENC_W'(GATED_FIELDS[i]) | 32'h1);
      end
      wait_idle();
    end
  endtask

  task automatic test_random_traffic();
    for (int phase = 0; phase < 6; phase++) begin
      tx_gaps = (phase % 3 != 0);
      rx_gaps = (phase % 2 != 0);
      load_caps(random_caps());
      repeat (190) send_word(random_encoding());
      wait_idle();
    end
  endtask

  task automatic test_output_stall();
    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    load_caps(random_caps());
    repeat (2) @(posedge clk);
    hold_off = 1'b1;
    repeat (30) send_word(random_encoding());
    wait_idle();
  endtask

  initial begin
    req.valid <= 1'b0;
    req.field_encoding <= '0;
    cfg_write <= 1'b0;
    cfg_index <= REG_PIN;
    cfg_data <= '0;
    cap_model = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_decode_corners();
    test_capability_gating();
    test_random_traffic();
    test_output_stall();

    wait_idle();
    if (mismatches == 0) begin
      $display("[vmcs_field_encoding_checker] OK");
    end else begin
      $display("[vmcs_field_encoding_checker] ERROR");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+src
src/vfec_pkg.sv
src/vfec_if.sv
src/vfec_cfg_regs.sv
src/vfec_decode.sv
src/vmcs_field_encoding_checker.sv
verif/tb.sv
